### hdl/spq_pkg.sv
// shared constants and types for the sorted priority queue
// no dependencies; used by the channel interfaces and the queue itself
package spq_pkg;

   localparam int DEPTH_DEF = 16;

   localparam int REQ_TYPE_W = 2;
   localparam int KEY_W      = 16;
   localparam int PRIO_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SEARCH = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
   } entry_type;

endpackage

### hdl/spq_req_if.sv
// request channel of the sorted priority queue: valid/ready plus request payload
// depends on spq_pkg
interface spq_req_if;
   logic                          valid;
   logic                          ready;
   logic [spq_pkg::REQ_TYPE_W-1:0] req_type;
   logic [spq_pkg::KEY_W-1:0]      room;
   logic [spq_pkg::PRIO_W-1:0]     priority_req;

   modport source (output valid, output req_type, output room, output priority_req,
                   input ready);
   modport sink   (input valid, input req_type, input room, input priority_req,
                   output ready);
endinterface

### hdl/spq_rsp_if.sv
// result channel of the sorted priority queue: valid/ready plus result payload
// depends on spq_pkg
interface spq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spq_pkg::STATUS_W-1:0] status;
   logic [spq_pkg::KEY_W-1:0]    out_room;
   logic [spq_pkg::PRIO_W-1:0]   out_priority;
   logic [spq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output out_room, output out_priority,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input out_room, input out_priority,
                   input occupancy, output ready);
endinterface

### hdl/spq_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module spq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sorted_priority_queue.sv
// sorted priority queue top level: circular buffer in one ram, walked by a small sequencer
// depends on spq_pkg, spq_req_if, spq_rsp_if and spq_ram
//
//   channel | dir | handshake         | payload
//   req     | in  | valid/ready       | req_type, room, priority_req
//   rsp     | out | valid/ready       | status, out_room, out_priority, occupancy
//
// one request at a time; req is ready only when the sequencer is idle
// insert moves entries of greater priority back from the tail, then writes the new one;
// pop reads out the head entry; search compares live entries from the head to the first
// match or the last entry; refused requests and the unused code go straight to the result
// the single ram read port limits every walk to one live entry visited per cycle
// synchronous reset empties the queue at once; ram contents are left as they are
// a stalled result holds in its register until rsp ready, and no request is taken meanwhile
module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_INS_CMP  = 6'b000010,
      ST_PLACE    = 6'b000100,
      ST_POP_RD   = 6'b001000,
      ST_SRCH_CMP = 6'b010000,
      ST_RESP     = 6'b100000
   } state_type;

   function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] offs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[AW-1:0];
   endfunction

   state_type                   state_ff, state_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [spq_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [spq_pkg::PRIO_W-1:0]  prio_ff, prio_in;
   logic [spq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [spq_pkg::KEY_W-1:0]   out_key_ff, out_key_in;
   logic [spq_pkg::PRIO_W-1:0]  out_prio_ff, out_prio_in;

   logic                        accept;
   logic                        wr_en;
   logic [AW-1:0]               wr_index;
   spq_pkg::entry_type          wr_data;
   logic [AW-1:0]               rd_index;
   spq_pkg::entry_type          rd_data;
   logic [CW+spq_pkg::OCC_W-1:0] occ_ext;

   assign accept = req.valid && req.ready;

   spq_ram #(
      .WIDTH($bits(spq_pkg::entry_type)),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wrap_addr(head_ff, wr_index)),
      .wr_data(wr_data),
      .rd_addr(wrap_addr(head_ff, rd_index)),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      key_in      = key_ff;
      prio_in     = prio_ff;
      status_in   = status_ff;
      out_key_in  = out_key_ff;
      out_prio_in = out_prio_ff;
      wr_en       = 1'b0;
      wr_index    = idx_ff;
      wr_data     = '{key: key_ff, prio: prio_ff};
      rd_index    = '0;

      case (state_ff)
         ST_IDLE: begin
            // the first read goes out with the transfer: tail for insert, head otherwise
            if (req.req_type == spq_pkg::REQ_INSERT) begin
               rd_index = count_ff[AW-1:0] - AW'(1);
            end
            if (accept) begin
               key_in      = req.room;
               prio_in     = req.priority_req;
               status_in   = spq_pkg::STATUS_OK;
               out_key_in  = '0;
               out_prio_in = '0;
               state_in    = ST_RESP;
               case (req.req_type)
                  spq_pkg::REQ_INSERT: begin
                     idx_in = count_ff[AW-1:0];
                     if (count_ff == DEPTH_CNT) begin
                        status_in = spq_pkg::STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = ST_PLACE;
                     end else begin
                        state_in = ST_INS_CMP;
                     end
                  end
                  spq_pkg::REQ_POP: begin
                     if (count_ff == '0) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = ST_POP_RD;
                     end
                  end
                  spq_pkg::REQ_SEARCH: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        status_in = spq_pkg::STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_SRCH_CMP;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_INS_CMP: begin
            // rd_data holds entry idx-1; next read for idx-2 goes out while we decide
            rd_index = idx_ff - AW'(2);
            if (rd_data.prio > prio_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_ff - AW'(1);
               if (idx_ff == AW'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_RESP;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_RESP;
         end

         ST_POP_RD: begin
            out_key_in  = rd_data.key;
            out_prio_in = rd_data.prio;
            head_in     = wrap_addr(head_ff, AW'(1));
            count_in    = count_ff - CW'(1);
            state_in    = ST_RESP;
         end

         ST_SRCH_CMP: begin
            rd_index = idx_ff + AW'(1);
            if (rd_data.key == key_ff) begin
               out_key_in  = rd_data.key;
               out_prio_in = rd_data.prio;
               state_in    = ST_RESP;
            end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
               status_in = spq_pkg::STATUS_NOT_FOUND;
               state_in  = ST_RESP;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         ST_RESP: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      key_ff      <= key_in;
      prio_ff     <= prio_in;
      status_ff   <= status_in;
      out_key_ff  <= out_key_in;
      out_prio_ff <= out_prio_in;
   end

   assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_ff};

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = (state_ff == ST_RESP);
   assign rsp.status       = status_ff;
   assign rsp.out_room     = out_key_ff;
   assign rsp.out_priority = out_prio_ff;
   assign rsp.occupancy    = occ_ext[spq_pkg::OCC_W-1:0];

`ifndef NO_ASSERTIONS
   // a full refusal is only reported when the queue really holds DEPTH entries
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == spq_pkg::STATUS_FULL) |-> (count_ff == DEPTH_CNT))
      else $error("full status reported with room in the queue");

   // one request in flight: never taking a request while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("request taken while a result is pending");

   // the count only grows through a ram write of the new entry
   a_count_grows_on_write: assert property (@(posedge clock) disable iff (reset)
      (count_ff > $past(count_ff)) |-> $past(wr_en))
      else $error("occupancy grew without an entry written");

   // an empty status is only reported when the queue holds no entries
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == spq_pkg::STATUS_EMPTY) |-> (count_ff == '0))
      else $error("empty status reported with live entries");
`endif

endmodule

### bench/tb_sorted_priority_queue.sv
// self-checking bench for sorted_priority_queue: directed then random requests, with an
// in-bench model of the sorted queue predicting every result
// depends on spq_pkg, spq_req_if, spq_rsp_if and the queue rtl
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

   localparam int Q_DEPTH = spq_pkg::DEPTH_DEF;
   localparam logic [spq_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 1075;
   localparam int LONG_STALL_CYCLES = 250;

   typedef struct packed {
      logic [spq_pkg::REQ_TYPE_W-1:0] kind;
      logic [spq_pkg::KEY_W-1:0]      key;
      logic [spq_pkg::PRIO_W-1:0]     prio;
   } request_type;

   typedef struct packed {
      logic [spq_pkg::STATUS_W-1:0] status;
      logic [spq_pkg::KEY_W-1:0]    key;
      logic [spq_pkg::PRIO_W-1:0]   prio;
      logic [spq_pkg::OCC_W-1:0]    occupancy;
   } result_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue #(.DEPTH(Q_DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of the queue contents, kept sorted exactly as the block keeps them
   logic [spq_pkg::KEY_W-1:0]  model_keys [Q_DEPTH];
   logic [spq_pkg::PRIO_W-1:0] model_prios[Q_DEPTH];
   int                         model_count;

   request_type pending_requests[$];
   result_type  expected_results[$];

   int total_requests;
   int sent_count;
   int failures;
   int reports;
   int inserts, refused_full, pops, pops_empty, searches, search_misses, unused_codes;
   int peak_count;
   int long_stalls;
   int stall_left;
   int stall_trigger;

   function automatic result_type predict_queue_result(request_type r);
      result_type res;
      int         i;
      res = '0;
      case (r.kind)
         spq_pkg::REQ_INSERT: begin
            inserts++;
            if (model_count >= Q_DEPTH) begin
               res.status = spq_pkg::STATUS_FULL;
               refused_full++;
            end else begin
               // entries of strictly greater priority move back one place
               i = model_count;
               while (i > 0 && model_prios[i-1] > r.prio) begin
                  model_keys[i]  = model_keys[i-1];
                  model_prios[i] = model_prios[i-1];
                  i--;
               end
               model_keys[i]  = r.key;
               model_prios[i] = r.prio;
               model_count++;
               res.status = spq_pkg::STATUS_OK;
            end
         end
         spq_pkg::REQ_POP: begin
            pops++;
            if (model_count == 0) begin
               res.status = spq_pkg::STATUS_EMPTY;
               pops_empty++;
            end else begin
               res.status = spq_pkg::STATUS_OK;
               res.key    = model_keys[0];
               res.prio   = model_prios[0];
               for (i = 1; i < model_count; i++) begin
                  model_keys[i-1]  = model_keys[i];
                  model_prios[i-1] = model_prios[i];
               end
               model_count--;
            end
         end
         spq_pkg::REQ_SEARCH: begin
            searches++;
            res.status = spq_pkg::STATUS_NOT_FOUND;
            for (i = 0; i < model_count; i++) begin
               if (model_keys[i] == r.key) begin
                  res.status = spq_pkg::STATUS_OK;
                  res.key    = model_keys[i];
                  res.prio   = model_prios[i];
                  break;
               end
            end
            if (res.status == spq_pkg::STATUS_NOT_FOUND)
               search_misses++;
         end
         default: begin
            unused_codes++;
            res.status = spq_pkg::STATUS_OK;
         end
      endcase
      if (model_count > peak_count)
         peak_count = model_count;
      res.occupancy = model_count[spq_pkg::OCC_W-1:0];
      return res;
   endfunction

   function automatic void add_request(logic [spq_pkg::REQ_TYPE_W-1:0] kind,
                                       logic [spq_pkg::KEY_W-1:0] key,
                                       logic [spq_pkg::PRIO_W-1:0] prio);
      request_type r;
      r.kind = kind;
      r.key  = key;
      r.prio = prio;
      pending_requests.push_back(r);
   endfunction

   // small key pool most of the time so searches hit and duplicates occur
   function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(0, 3) == 0)
         return spq_pkg::KEY_W'($urandom);
      return spq_pkg::KEY_W'($urandom_range(0, 15));
   endfunction

   // narrow priorities half of the time to provoke ties
   function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
      if ($urandom_range(0, 1) == 0)
         return spq_pkg::PRIO_W'($urandom_range(0, 3));
      return spq_pkg::PRIO_W'($urandom);
   endfunction

   // idling phases cycle with progress: none, sender, receiver, both
   function automatic int sender_idle_pct();
      case ((sent_count / 120) % 4)
         1: return 52;
         3: return 19;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case ((sent_count / 120) % 4)
         2: return 52;
         3: return 19;
         default: return 0;
      endcase
   endfunction

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = '0;
      req_ch.room         = '0;
      req_ch.priority_req = '0;
      rsp_ch.ready        = 1'b0;
   end

   // request driver: predicts on each transfer, then offers the next pending item
   always @(posedge clock) begin : request_driver
      request_type taken;
      request_type next_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.kind = req_ch.req_type;
            taken.key  = req_ch.room;
            taken.prio = req_ch.priority_req;
            expected_results.push_back(predict_queue_result(taken));
            sent_count <= sent_count + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct()) begin
               next_req = pending_requests.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.req_type     <= next_req.kind;
               req_ch.room         <= next_req.key;
               req_ch.priority_req <= next_req.prio;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long response hold-off, twice in the run, so the request side backs up
   always @(posedge clock) begin
      if (reset) begin
         stall_left    <= 0;
         stall_trigger <= 300;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (sent_count >= stall_trigger) begin
         stall_left    <= LONG_STALL_CYCLES;
         stall_trigger <= stall_trigger + 450;
         long_stalls++;
      end
   end

   // result monitor: checks each transfer against the oldest prediction
   always @(posedge clock) begin : result_monitor
      result_type want;
      result_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status    = rsp_ch.status;
            got.key       = rsp_ch.out_room;
            got.prio      = rsp_ch.out_priority;
            got.occupancy = rsp_ch.occupancy;
            if (expected_results.size() == 0) begin
               failures++;
               if (reports < 10)
                  $display("%0t: unexpected result: status %0d key %h prio %h occ %0d",
                           $time, got.status, got.key, got.prio, got.occupancy);
               reports++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.key !== want.key ||
                   got.prio !== want.prio || got.occupancy !== want.occupancy) begin
                  failures++;
                  if (reports < 10) begin
                     $display("%0t: mismatch: expected status %0d key %h prio %h occ %0d",
                              $time, want.status, want.key, want.prio, want.occupancy);
                     $display("%0t:           got status %0d key %h prio %h occ %0d",
                              $time, got.status, got.key, got.prio, got.occupancy);
                  end
                  reports++;
               end
            end
         end
         rsp_ch.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct());
      end
   end

   initial begin : stimulus
      int produced;
      int burst_len;
      int burst_kind;
      int pick;
      int i;

      // empty queue corner cases
      add_request(spq_pkg::REQ_POP, 16'h0000, 8'h00);
      add_request(spq_pkg::REQ_SEARCH, 16'h0000, 8'h00);
      add_request(REQ_UNUSED, 16'hffff, 8'hff);
      // fill to the brim with extremes, ties and a duplicated key
      add_request(spq_pkg::REQ_INSERT, 16'h0000, 8'h00);
      add_request(spq_pkg::REQ_INSERT, 16'hffff, 8'hff);
      add_request(spq_pkg::REQ_INSERT, 16'h00ff, 8'h80);
      add_request(spq_pkg::REQ_INSERT, 16'hff00, 8'h80);
      add_request(spq_pkg::REQ_INSERT, 16'h1234, 8'h00);
      add_request(spq_pkg::REQ_INSERT, 16'h1234, 8'h40);
      add_request(spq_pkg::REQ_INSERT, 16'haaaa, 8'h80);
      add_request(spq_pkg::REQ_INSERT, 16'h5555, 8'h7f);
      add_request(spq_pkg::REQ_INSERT, 16'h1111, 8'h01);
      add_request(spq_pkg::REQ_INSERT, 16'h2222, 8'hfe);
      add_request(spq_pkg::REQ_INSERT, 16'h3333, 8'h80);
      add_request(spq_pkg::REQ_INSERT, 16'h4444, 8'h00);
      add_request(spq_pkg::REQ_INSERT, 16'h6666, 8'hff);
      add_request(spq_pkg::REQ_INSERT, 16'h7777, 8'h10);
      add_request(spq_pkg::REQ_INSERT, 16'h8888, 8'h20);
      add_request(spq_pkg::REQ_INSERT, 16'h9999, 8'h30);
      add_request(spq_pkg::REQ_INSERT, 16'hbeef, 8'h00);
      // first match wins, the entry next to the tail is reachable, and popped keys are gone
      add_request(spq_pkg::REQ_SEARCH, 16'h1234, 8'hff);
      add_request(spq_pkg::REQ_SEARCH, 16'hffff, 8'h00);
      add_request(REQ_UNUSED, 16'h0000, 8'h00);
      add_request(spq_pkg::REQ_POP, 16'hffff, 8'hff);
      add_request(spq_pkg::REQ_SEARCH, 16'h0000, 8'h00);

      // random bursts: fill runs, drain runs and mixed traffic
      produced = 0;
      while (produced < RANDOM_REQUESTS) begin
         burst_kind = $urandom_range(0, 9);
         burst_len  = $urandom_range(10, 20);
         for (i = 0; i < burst_len; i++) begin
            if (burst_kind < 2) begin
               add_request(spq_pkg::REQ_INSERT, pick_key(), pick_prio());
            end else if (burst_kind < 4) begin
               add_request(spq_pkg::REQ_POP, spq_pkg::KEY_W'($urandom),
                           spq_pkg::PRIO_W'($urandom));
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 45)
                  add_request(spq_pkg::REQ_INSERT, pick_key(), pick_prio());
               else if (pick < 70)
                  add_request(spq_pkg::REQ_POP, spq_pkg::KEY_W'($urandom),
                              spq_pkg::PRIO_W'($urandom));
               else if (pick < 96)
                  add_request(spq_pkg::REQ_SEARCH, pick_key(), spq_pkg::PRIO_W'($urandom));
               else
                  add_request(REQ_UNUSED, spq_pkg::KEY_W'($urandom),
                              spq_pkg::PRIO_W'($urandom));
            end
            if (!(burst_kind >= 4 && pick >= 96))
               produced++;
            pick = 0;
         end
      end
      total_requests = pending_requests.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (sent_count != total_requests)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (2 * Q_DEPTH + 10) @(posedge clock);

      $display("covered %0d requests: %0d inserts (%0d refused full), %0d pops (%0d on empty),",
               sent_count, inserts, refused_full, pops, pops_empty);
      $display("%0d searches (%0d missed), %0d unused codes, peak fill %0d, %0d long stalls",
               searches, search_misses, unused_codes, peak_count, long_stalls);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
